// ===== design/otcs_pkg.sv =====
// Types, command codes and font tables for the OLED text command sequencer.
`timescale 1ns / 1ps

package otcs_pkg;

   // Operation codes on the input channel
   localparam logic [1:0] OP_INIT      = 2'd0;
   localparam logic [1:0] OP_CELL_CHAR = 2'd1;
   localparam logic [1:0] OP_NEXT_CHAR = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   // Configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_CONTRAST_LEVEL = 1'b1;

   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd60;
   localparam logic [7:0] CONTRAST_LEVEL_RESET = 8'd32;

   // Control bytes and controller commands
   localparam logic [7:0] CTRL_COMMAND   = 8'h00;
   localparam logic [7:0] CTRL_DATA      = 8'h40;
   localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'hAF;
   localparam logic [7:0] CMD_SEG_REMAP   = 8'hA1;
   localparam logic [7:0] CMD_COM_REVERSE = 8'hC8;
   localparam logic [7:0] CMD_CHARGE_PUMP = 8'h8D;
   localparam logic [7:0] ARG_PUMP_ON     = 8'h14;
   localparam logic [7:0] CMD_CONTRAST    = 8'h81;
   localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH    = 8'h10;
   localparam logic [7:0] CMD_COL_LOW     = 8'h00;

   localparam int FONT_ROWS = 30;
   localparam int MAP_ROWS  = 96;

   // Last step index per operation
   localparam logic [4:0] INIT_LAST_STEP = 5'd13;
   localparam logic [4:0] CHAR_LAST_STEP = 5'd29;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_INIT = 3'b010,
      ST_CHAR = 3'b100
   } state_type;

   // One issued bus byte on its way to the output register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       use_font;
      logic       start;
      logic       stop;
      logic       last;
   } beat_type;

   // ASCII 32..127 to glyph number
   localparam logic [4:0] CODE_MAP [MAP_ROWS] = '{
      5'h0a,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,
      5'h05,5'h06,5'h00,5'h00,5'h00,5'h09,5'h0b,5'h00,
      5'h0d,5'h0e,5'h0f,5'h10,5'h11,5'h12,5'h13,5'h14,
      5'h15,5'h16,5'h00,5'h00,5'h07,5'h00,5'h08,5'h00,
      5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,
      5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,
      5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h17,5'h18,
      5'h19,5'h1a,5'h00,5'h03,5'h00,5'h04,5'h00,5'h00,
      5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,
      5'h00,5'h00,5'h00,5'h00,5'h00,5'h1b,5'h00,5'h00,
      5'h1c,5'h00,5'h1d,5'h00,5'h00,5'h00,5'h00,5'h00,
      5'h00,5'h00,5'h00,5'h01,5'h00,5'h02,5'h0c,5'h00
   };

   // Glyph rows, first column byte in the top bits
   localparam logic [63:0] GLYPH_UPPER [FONT_ROWS] = '{
      64'hff010101010101ff, 64'he0180482021139_7d, 64'h111122c20418e000,
      64'he018044212010901, 64'h0901124204_18e000, 64'he01804020_2f109c9,
      64'h69f1020204_18e000, 64'h80c0e0f0f8c0c0c0, 64'hc0c0c0f8f0e0c080,
      64'h0080808080808000, 64'h0000000000000000, 64'h0000000000000000,
      64'h00e0e00000e0e000, 64'h0000f0f80868f8f0, 64'h00202030f8f80000,
      64'h0030380888f87000, 64'h0030388888f87000, 64'h0000f8f800e0e000,
      64'h00f8f88888880800, 64'h00c0e07858c88000, 64'h00080888e8781800,
      64'h0070f8c888f87000, 64'h00f0f80808f8f000, 64'h8060909060800000,
      64'h0000806090906080, 64'h0060909060000000, 64'h0000006090906000,
      64'h00e0e020e020e0c0, 64'h00e0e02020e0c000, 64'h00e0e08040606000
   };

   localparam logic [63:0] GLYPH_LOWER [FONT_ROWS] = '{
      64'h7f4040404040407f, 64'h030c102126444848, 64'h48442621100c0300,
      64'h030c102124404840, 64'h48402421100c0300, 64'h030c102020474b49,
      64'h48472020100c0300, 64'h000103070f010101, 64'h0101010f07030100,
      64'h0000000000000000, 64'h0000000000000000, 64'h0000000c0c0c0000,
      64'h407f3f0808070f08, 64'h0000070f0b080f07, 64'h000000000f0f0000,
      64'h000c0e0b09080800, 64'h00060e08080f0700, 64'h00030302020f0f02,
      64'h000808080c070300, 64'h00070f08080f0700, 64'h00000e0f01000000,
      64'h00070f08090f0700, 64'h0000090d0f030100, 64'h070000000003_0c12,
      64'h120c030000000007, 64'h0000000000000c12, 64'h120c000000000000,
      64'h000f0f0007000f0f, 64'h007f7f08080f0700, 64'h000f0f0000000000
   };

endpackage

// ===== design/oled_text_command_sequencer_top.sv =====
// Top level of the OLED text command sequencer: operation decode, byte sequencer, output stage.
`timescale 1ns / 1ps

// Usage
//   req_* channel: one display operation per beat (initialize, character at a
//   cell, next character; operation 3 is taken and dropped). rsp_* channel: one
//   I2C bus byte per beat with start/stop framing flags and rsp_last on the
//   final byte of an operation. csr_* channel: register writes, always ready;
//   index 0 device address, index 1 contrast. Write registers only while idle.
// Path: once the request beat is taken, the first byte of an operation passes
//   the sequencer state register, the font read stage and the output register.
// Throughput: one bus byte per cycle from the step counter of the sequencer
//   while rsp_stall does not hold the output; a character gives 30 bytes, an
//   initialize 14, an unused operation none. The next request is taken in the
//   cycle the last byte of the current one issues, so operations follow without gaps.
// Reset: synchronous; clears the sequencer, the pipeline valids, the cursor
//   (column 0, page 0) and sets the registers to address 60, contrast 32.
// Stall: rsp_stall holds the output register; the font read stage and the
//   sequencer stop behind it and req_stall stays high until the last byte of
//   the current operation has issued.
module oled_text_command_sequencer_top
   import otcs_pkg::*;
#(
   parameter int GLYPH_COUNT = 30,
   parameter int MAP_ENTRIES = 96
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_char_code,
   input  logic [3:0] req_text_column,
   input  logic [1:0] req_text_row,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_bus_address,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_transfer_start,
   output logic       rsp_transfer_stop,
   output logic       rsp_last,
   // register write channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);

   // registers
   logic [6:0] device_address_ff;
   logic [7:0] contrast_level_ff;

   // cursor
   logic [7:0] cursor_column_ff, cursor_column_in;
   logic [2:0] cursor_page_ff, cursor_page_in;

   // sequencer
   state_type  state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [4:0] glyph_ff, glyph_in;
   logic [7:0] column_ff, column_in;
   logic [2:0] page_ff, page_in;

   // font read stage and output stage
   logic       s1_valid_ff, s1_valid_in;
   beat_type   s1_beat_ff, issue_beat;
   logic [7:0] font_q_ff;
   logic       out_valid_ff, out_valid_in;
   beat_type   out_beat_ff;
   logic [7:0] out_byte_ff;

   logic       out_ready, s1_ready, issue, last_step, accept;
   logic [4:0] map_glyph;
   logic [6:0] map_idx;
   logic [2:0] font_idx;
   logic [2:0] setup_page;
   logic [4:0] setup_step;

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         contrast_level_ff <= CONTRAST_LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: device_address_ff <= csr_data[6:0];
            CSR_CONTRAST_LEVEL: contrast_level_ff <= csr_data;
            default:            device_address_ff <= device_address_ff;
         endcase
      end
   end

   // pipeline handshake
   assign out_ready = !out_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign issue     = (state_ff != ST_IDLE) && s1_ready;
   assign last_step = ((state_ff == ST_INIT) && (step_ff == INIT_LAST_STEP)) ||
                      ((state_ff == ST_CHAR) && (step_ff == CHAR_LAST_STEP));
   assign req_stall = (state_ff != ST_IDLE) && !(issue && last_step);
   assign accept    = req_valid && !req_stall;

   // code to glyph lookup
   always_comb begin
      map_idx   = req_char_code[6:0] - 7'd32;
      map_glyph = CODE_MAP[map_idx];
      if (req_char_code[7] || (req_char_code[6:5] == 2'b00) ||
          (32'(map_idx) >= MAP_ENTRIES) || (32'(map_glyph) >= GLYPH_COUNT))
         map_glyph = '0;
   end

   // operation decode and cursor update
   always_comb begin
      state_in         = state_ff;
      step_in          = step_ff;
      glyph_in         = glyph_ff;
      column_in        = column_ff;
      page_in          = page_ff;
      cursor_column_in = cursor_column_ff;
      cursor_page_in   = cursor_page_ff;
      if (issue) begin
         step_in = step_ff + 5'd1;
         if (last_step)
            state_in = ST_IDLE;
      end
      if (accept) begin
         step_in = '0;
         unique case (req_operation)
            OP_INIT: begin
               state_in         = ST_INIT;
               cursor_column_in = '0;
               cursor_page_in   = '0;
            end
            OP_CELL_CHAR: begin
               state_in         = ST_CHAR;
               glyph_in         = map_glyph;
               column_in        = {req_text_column, 3'b000};
               page_in          = {req_text_row, 1'b0};
               cursor_column_in = {req_text_column, 3'b000} + 8'd8;
               cursor_page_in   = {req_text_row, 1'b0};
            end
            OP_NEXT_CHAR: begin
               state_in         = ST_CHAR;
               glyph_in         = map_glyph;
               column_in        = cursor_column_ff;
               page_in          = cursor_page_ff;
               cursor_column_in = cursor_column_ff + 8'd8;
            end
            OP_UNUSED: state_in = ST_IDLE;
            default:   state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         step_ff          <= '0;
         cursor_column_ff <= '0;
         cursor_page_ff   <= '0;
      end else begin
         state_ff         <= state_in;
         step_ff          <= step_in;
         cursor_column_ff <= cursor_column_in;
         cursor_page_ff   <= cursor_page_in;
      end
      glyph_ff  <= glyph_in;
      column_ff <= column_in;
      page_ff   <= page_in;
   end

   // byte selection for the current step
   always_comb begin
      setup_page = (step_ff < 5'd15) ? page_ff : page_ff + 3'd1;
      setup_step = (step_ff < 5'd15) ? step_ff : step_ff - 5'd15;
      issue_beat = '{data_byte: CTRL_COMMAND, use_font: 1'b0,
                     start: 1'b0, stop: 1'b0, last: last_step};
      if (state_ff == ST_INIT) begin
         unique case (step_ff)
            5'd1:  begin issue_beat.data_byte = CMD_DISPLAY_OFF; issue_beat.stop = 1'b1; end
            5'd3:  begin issue_beat.data_byte = CMD_SEG_REMAP;   issue_beat.stop = 1'b1; end
            5'd5:  begin issue_beat.data_byte = CMD_COM_REVERSE; issue_beat.stop = 1'b1; end
            5'd7:  issue_beat.data_byte = CMD_CHARGE_PUMP;
            5'd8:  begin issue_beat.data_byte = ARG_PUMP_ON;     issue_beat.stop = 1'b1; end
            5'd10: issue_beat.data_byte = CMD_CONTRAST;
            5'd11: begin issue_beat.data_byte = contrast_level_ff; issue_beat.stop = 1'b1; end
            5'd13: begin issue_beat.data_byte = CMD_DISPLAY_ON;  issue_beat.stop = 1'b1; end
            5'd0, 5'd2, 5'd4, 5'd6, 5'd9, 5'd12: issue_beat.start = 1'b1;
            default: issue_beat.data_byte = CTRL_COMMAND;
         endcase
      end else begin
         unique case (setup_step)
            5'd0: issue_beat.start = 1'b1;
            5'd1: issue_beat.data_byte = CMD_PAGE_BASE | {5'b00000, setup_page};
            5'd3: issue_beat.data_byte = CMD_COL_HIGH | {4'h0, column_ff[7:4]};
            5'd5: begin
               issue_beat.data_byte = CMD_COL_LOW | {4'h0, column_ff[3:0]};
               issue_beat.stop      = 1'b1;
            end
            5'd6: begin
               issue_beat.data_byte = CTRL_DATA;
               issue_beat.start     = 1'b1;
            end
            5'd2, 5'd4: issue_beat.data_byte = CTRL_COMMAND;
            default: begin
               issue_beat.use_font = 1'b1;
               issue_beat.stop     = (setup_step == 5'd14);
            end
         endcase
      end
   end

   // glyph column within the current half
   assign font_idx = (step_ff < 5'd15) ? 3'(step_ff - 5'd7) : 3'(step_ff - 5'd22);

   // font read stage: registered table read, then output register
   assign s1_valid_in  = issue || (s1_valid_ff && !out_ready);
   assign out_valid_in = (s1_valid_ff && out_ready) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (issue) begin
         s1_beat_ff <= issue_beat;
         if (step_ff < 5'd15)
            font_q_ff <= GLYPH_UPPER[glyph_ff][8*(7-font_idx) +: 8];
         else
            font_q_ff <= GLYPH_LOWER[glyph_ff][8*(7-font_idx) +: 8];
      end
      if (s1_valid_ff && out_ready) begin
         out_beat_ff <= s1_beat_ff;
         out_byte_ff <= s1_beat_ff.use_font ? font_q_ff : s1_beat_ff.data_byte;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_bus_address    = device_address_ff;
   assign rsp_data_byte      = out_byte_ff;
   assign rsp_transfer_start = out_beat_ff.start;
   assign rsp_transfer_stop  = out_beat_ff.stop;
   assign rsp_last           = out_beat_ff.last;

endmodule

// ===== design/otcs_checker.sv =====
// Port-level checks for the OLED text command sequencer, bound to the top level.
`timescale 1ns / 1ps

module otcs_checker
   import otcs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_transfer_start,
   input logic       rsp_transfer_stop,
   input logic       rsp_last
);

   // output stage is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled beat holds its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_byte))
      else $error("stalled response beat changed");

   // the last byte of an operation closes a transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_transfer_stop)
      else $error("last byte without stop");

   // every transfer opens with a control byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_transfer_start |->
         (rsp_data_byte == CTRL_COMMAND) || (rsp_data_byte == CTRL_DATA))
      else $error("transfer opened with a non-control byte");

endmodule

bind oled_text_command_sequencer_top otcs_checker u_otcs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_transfer_start (rsp_transfer_start),
   .rsp_transfer_stop  (rsp_transfer_stop),
   .rsp_last           (rsp_last)
);
